// File: sv/mbet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbet_pkg;

  // Field widths of the streams.
  localparam int COORD_W    = 10;
  localparam int COUNT_W    = 12;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 40;

  // Fixed point: Q4.28 coordinates, Q8.56 products.
  localparam int FRAC_BITS = 28;
  localparam int STEP_W    = 31;
  localparam int CTR_W     = 32;
  localparam int ZS_W      = 32;
  localparam int PROD_W    = 64;
  localparam logic [PROD_W-1:0] LIMIT_Q856 = 64'h0400_0000_0000_0000;
  localparam logic [ZS_W-1:0]   MIN_Q428   = 32'h8000_0000;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_PIXEL_STEP  = 2'd0,
    REG_CENTER_REAL = 2'd1,
    REG_CENTER_IMAG = 2'd2,
    REG_MAX_ITER    = 2'd3
  } reg_idx_t;

  // Coordinate queue between the mapper and the iterator.
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  // Settings the coordinate mapper needs.
  typedef struct packed {
    logic [STEP_W-1:0]       step;
    logic signed [CTR_W-1:0] center_re;
    logic signed [CTR_W-1:0] center_im;
  } map_cfg_t;

  // One finished pixel, last field in the low bits.
  typedef struct packed {
    logic               escaped;
    logic [COUNT_W-1:0] count;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } result_t;

endpackage

`default_nettype wire

// File: sv/mbet_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module mbet_fifo #(
  parameter int DW = 112
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0]             mem_r [mbet_pkg::QDEPTH];
  logic [mbet_pkg::QAW-1:0]  wr_ptr_r;
  logic [mbet_pkg::QAW-1:0]  rd_ptr_r;
  logic [mbet_pkg::QAW:0]    cnt_r;

  assign full  = (cnt_r == (mbet_pkg::QAW + 1)'(mbet_pkg::QDEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == mbet_pkg::QAW'(mbet_pkg::QDEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == mbet_pkg::QAW'(mbet_pkg::QDEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: sv/mbet_map.sv
`timescale 1ns / 1ps
`default_nettype none

module mbet_map #(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024,
  parameter int HPW          = 12,
  parameter int CW           = 44
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mbet_pkg::map_cfg_t                    cfg,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [mbet_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                  q_push,
  output logic [2*mbet_pkg::COORD_W+2*CW-1:0]   q_data,
  input  logic                                  q_full
);

  logic [mbet_pkg::COORD_W-1:0] px;
  logic [mbet_pkg::COORD_W-1:0] py;
  logic signed [HPW-1:0]        half_x;
  logic signed [HPW-1:0]        half_y;
  logic signed [mbet_pkg::CTR_W-1:0] step_s;
  logic signed [CW-1:0]         prod_x;
  logic signed [CW-1:0]         prod_y;
  logic signed [CW-1:0]         c_re;
  logic signed [CW-1:0]         c_im;

  logic                         fv_r;
  logic [mbet_pkg::COORD_W-1:0] fx_r;
  logic [mbet_pkg::COORD_W-1:0] fy_r;
  logic signed [CW-1:0]         prx_r;
  logic signed [CW-1:0]         pry_r;
  logic                         accept;

  assign px = in_tdata[mbet_pkg::COORD_W-1:0];
  assign py = in_tdata[2*mbet_pkg::COORD_W-1:mbet_pkg::COORD_W];

  // Offset from the image center in half pixels: 2*p - size.
  assign half_x = HPW'({px, 1'b0}) - HPW'(IMAGE_WIDTH);
  assign half_y = HPW'({py, 1'b0}) - HPW'(IMAGE_HEIGHT);
  assign step_s = {1'b0, cfg.step};
  assign prod_x = half_x * step_s;
  assign prod_y = half_y * step_s;

  assign q_push    = fv_r && !q_full;
  assign in_tready = !fv_r || !q_full;
  assign accept    = in_tvalid && in_tready;

  // Halve the product (floor) and add the center.
  assign c_re = $signed({{(CW - mbet_pkg::CTR_W){cfg.center_re[mbet_pkg::CTR_W-1]}},
                         cfg.center_re})
              + (prx_r >>> 1);
  assign c_im = $signed({{(CW - mbet_pkg::CTR_W){cfg.center_im[mbet_pkg::CTR_W-1]}},
                         cfg.center_im})
              + (pry_r >>> 1);
  assign q_data = {c_im, c_re, fy_r, fx_r};

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (accept) begin
      fv_r <= 1'b1;
    end else if (q_push) begin
      fv_r <= 1'b0;
    end
  end

  // Stage payload: coordinates and scaled offsets.
  always_ff @(posedge clk) begin
    if (accept) begin
      fx_r  <= px;
      fy_r  <= py;
      prx_r <= prod_x;
      pry_r <= prod_y;
    end
  end

endmodule

`default_nettype wire

// File: sv/mbet_iter.sv
`timescale 1ns / 1ps
`default_nettype none

module mbet_iter #(
  parameter int CW = 44
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [mbet_pkg::COUNT_W-1:0]          max_iter,
  input  logic                                  q_valid,
  input  logic [2*mbet_pkg::COORD_W+2*CW-1:0]   q_data,
  output logic                                  q_pop,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output mbet_pkg::result_t                     res
);

  localparam int ZW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [mbet_pkg::COORD_W-1:0]      x_r;
  logic [mbet_pkg::COORD_W-1:0]      y_r;
  logic signed [CW-1:0]              cre_r;
  logic signed [CW-1:0]              cim_r;
  logic signed [ZW-1:0]              zre_r;
  logic signed [ZW-1:0]              zim_r;
  logic [mbet_pkg::COUNT_W-1:0]      cnt_r;
  logic signed [mbet_pkg::PROD_W-1:0] sq_re_r;
  logic signed [mbet_pkg::PROD_W-1:0] sq_im_r;
  logic signed [mbet_pkg::PROD_W-1:0] cross_r;
  logic                              ov_r;
  mbet_pkg::result_t                 res_r;

  logic signed [mbet_pkg::ZS_W-1:0]  zs_re;
  logic signed [mbet_pkg::ZS_W-1:0]  zs_im;
  logic                              re_ok;
  logic                              im_ok;
  logic [mbet_pkg::PROD_W-1:0]       mag_sum;
  logic                              stop;
  logic signed [mbet_pkg::PROD_W-1:0] diff;
  logic signed [ZW-1:0]              zre_nxt;
  logic signed [ZW-1:0]              zim_nxt;
  logic                              out_free;

  // A component is usable while its magnitude stays below 8.0.
  assign re_ok = (zre_r[ZW-1:31] == {(ZW - 31){zre_r[ZW-1]}})
              && (zre_r[mbet_pkg::ZS_W-1:0] != mbet_pkg::MIN_Q428);
  assign im_ok = (zim_r[ZW-1:31] == {(ZW - 31){zim_r[ZW-1]}})
              && (zim_r[mbet_pkg::ZS_W-1:0] != mbet_pkg::MIN_Q428);
  assign zs_re = zre_r[mbet_pkg::ZS_W-1:0];
  assign zs_im = zim_r[mbet_pkg::ZS_W-1:0];

  // Escape test on the squares, and the iteration limit.
  assign mag_sum = sq_re_r + sq_im_r;
  assign stop    = (mag_sum > mbet_pkg::LIMIT_Q856) || (cnt_r >= max_iter);

  // z*z + c, products brought back to Q4.28 with floor rounding.
  assign diff    = sq_re_r - sq_im_r;
  assign zre_nxt = {{(ZW - 36){diff[63]}}, diff[63:mbet_pkg::FRAC_BITS]}
                 + {{(ZW - CW){cre_r[CW-1]}}, cre_r};
  assign zim_nxt = {{(ZW - 37){cross_r[63]}}, cross_r[63:mbet_pkg::FRAC_BITS-1]}
                 + {{(ZW - CW){cim_r[CW-1]}}, cim_r};

  assign out_free  = !ov_r || res_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign res_valid = ov_r;
  assign res       = res_r;

  // Sequencer: a multiply state and an update state per iteration.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = (re_ok && im_ok) ? S_UPD : S_DONE;
      end
      S_UPD: begin
        state_nxt = stop ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && out_free) begin
        ov_r <= 1'b1;
      end else if (res_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r   <= q_data[mbet_pkg::COORD_W-1:0];
      y_r   <= q_data[2*mbet_pkg::COORD_W-1:mbet_pkg::COORD_W];
      cre_r <= q_data[2*mbet_pkg::COORD_W +: CW];
      cim_r <= q_data[2*mbet_pkg::COORD_W+CW +: CW];
      zre_r <= '0;
      zim_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == S_MUL) begin
      sq_re_r <= zs_re * zs_re;
      sq_im_r <= zs_im * zs_im;
      cross_r <= zs_re * zs_im;
    end
    if ((state_r == S_UPD) && !stop) begin
      zre_r <= zre_nxt;
      zim_r <= zim_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if ((state_r == S_DONE) && out_free) begin
      res_r.x       <= x_r;
      res_r.y       <= y_r;
      res_r.count   <= cnt_r;
      res_r.escaped <= (cnt_r != max_iter);
    end
  end

`ifndef NO_ASSERTIONS
  // A popped coordinate starts a fresh iteration at count zero.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && q_valid) |=> (state_r == S_MUL && cnt_r == '0))
    else $error("iteration did not start cleanly after a pop");

  // An out-of-range component ends the iteration at once.
  a_range_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && !(re_ok && im_ok)) |=> (state_r == S_DONE))
    else $error("out-of-range component did not end the iteration");

  // A continuing update advances the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !stop) |=> (state_r == S_MUL && cnt_r == $past(cnt_r) + 1'b1))
    else $error("iteration count did not advance by one");

  // A finished pixel reaches the output register and frees the sequencer.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (ov_r && state_r == S_IDLE))
    else $error("finished pixel was not loaded into the output register");
`endif

endmodule

`default_nettype wire

// File: sv/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Mandelbrot escape-time evaluator, one pixel per transaction.
// The in_ stream carries a pixel column and row; the out_ stream returns the
// same coordinates with the iteration count and an escaped flag. The cfg_
// APB port sets the step per pixel, the image center and the iteration limit;
// change them only while no pixel is in flight.
// A front stage maps the pixel to a complex point (one multiply per axis)
// and places it in a two-entry queue. The back iterator takes one point at a
// time and runs a multiply step (three parallel 32x32 squares and products)
// and then an escape test and update step for each iteration; escaping pixels
// finish in fewer iterations than interior ones, which run to the limit.
// A finished result waits in an output register; while it waits the iterator
// holds its next result, but the front keeps taking pixels until the queue
// and the front stage are full, and then in_tready drops. A stalled out_tready
// never loses or repeats a result. Reset empties the queue, idles the iterator
// and restores the register defaults (step 2^-8, center 0, limit 100).
module mandelbrot_escape_time_unit #(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input: [9:0] pixel_x, [19:10] pixel_y, zero padded.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mbet_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Output: [9:0] out_x, [19:10] out_y, [31:20] iteration_count,
  // [32] escaped, zero padded.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mbet_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mbet_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [mbet_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [mbet_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int SZ_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int SZ_W   = $clog2(SZ_MAX + 1);
  localparam int HPW    = ((SZ_W > mbet_pkg::COORD_W + 1) ? SZ_W
                                                          : mbet_pkg::COORD_W + 1) + 1;
  localparam int CW     = HPW + mbet_pkg::CTR_W;
  localparam int QW     = 2 * mbet_pkg::COORD_W + 2 * CW;

  logic [mbet_pkg::STEP_W-1:0]    step_r;
  logic signed [mbet_pkg::CTR_W-1:0] center_re_r;
  logic signed [mbet_pkg::CTR_W-1:0] center_im_r;
  logic [mbet_pkg::COUNT_W-1:0]   max_iter_r;
  mbet_pkg::map_cfg_t             map_cfg;
  mbet_pkg::reg_idx_t             reg_idx;
  logic                           cfg_wr;

  logic                           q_push;
  logic [QW-1:0]                  q_wdata;
  logic                           q_full;
  logic                           q_pop;
  logic                           q_valid;
  logic [QW-1:0]                  q_rdata;
  mbet_pkg::result_t              res;

  // Register access.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = mbet_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= mbet_pkg::STEP_W'(1048576);
      center_re_r <= '0;
      center_im_r <= '0;
      max_iter_r  <= mbet_pkg::COUNT_W'(100);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mbet_pkg::REG_PIXEL_STEP:  step_r      <= cfg_pwdata[mbet_pkg::STEP_W-1:0];
        mbet_pkg::REG_CENTER_REAL: center_re_r <= cfg_pwdata;
        mbet_pkg::REG_CENTER_IMAG: center_im_r <= cfg_pwdata;
        mbet_pkg::REG_MAX_ITER:    max_iter_r  <= cfg_pwdata[mbet_pkg::COUNT_W-1:0];
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      mbet_pkg::REG_PIXEL_STEP:  cfg_prdata = {1'b0, step_r};
      mbet_pkg::REG_CENTER_REAL: cfg_prdata = center_re_r;
      mbet_pkg::REG_CENTER_IMAG: cfg_prdata = center_im_r;
      mbet_pkg::REG_MAX_ITER:
        cfg_prdata = {{(mbet_pkg::CFG_DW - mbet_pkg::COUNT_W){1'b0}}, max_iter_r};
    endcase
  end

  assign map_cfg.step      = step_r;
  assign map_cfg.center_re = center_re_r;
  assign map_cfg.center_im = center_im_r;

  // Front: pixel to complex point.
  mbet_map #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .HPW          (HPW),
    .CW           (CW)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (map_cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  // Queue between front and back.
  mbet_fifo #(
    .DW (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // Back: escape-time iteration.
  mbet_iter #(
    .CW (CW)
  ) u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_iter  (max_iter_r),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {{(mbet_pkg::OUT_TDATA_W - $bits(mbet_pkg::result_t)){1'b0}}, res};

endmodule

`default_nettype wire
